// File: rtl/core/cdq_pkg.sv
// Shared constants, operation and status codes, and the result word type for the deque.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_INDEX = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RESIZE     = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] back_value;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              is_full;
    } res_t;

endpackage

// File: rtl/core/cdq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
module cdq_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32,
    parameter int AW_P    = $clog2(DEPTH_P)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW_P-1:0]    waddr,
    input  logic [WIDTH_P-1:0] wdata,
    input  logic [AW_P-1:0]    raddr,
    output logic [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/cdq_ctrl.sv
// Deque sequencer: ring pointers, cached front/back words, RAM accesses and fill walk.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [DATA_W-1:0] value,
    input  logic [CNT_W-1:0]  position,
    output logic              res_valid,
    input  logic              res_free,
    output res_t              res,
    output logic              mem_we,
    output logic [PTR_W-1:0]  mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic [PTR_W-1:0]  mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [1:0] RD_FRONT = 2'd0;
    localparam logic [1:0] RD_BACK  = 2'd1;
    localparam logic [1:0] RD_INDEX = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [1:0]        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] back_reg, back_next;
    logic [DATA_W-1:0] fill_val_reg, fill_val_next;
    logic [CNT_W-1:0]  fill_idx_reg, fill_idx_next;
    logic [CNT_W-1:0]  target_reg, target_next;
    logic [1:0]        sel_reg, sel_next;
    logic              finish;
    logic [CNT_W-1:0]  cnt_m2;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  fill_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign pos_m1   = position - CNT_W'(1);
    assign fill_inc = fill_idx_reg + CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        rd_next       = rd_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        fill_val_next = fill_val_reg;
        fill_idx_next = fill_idx_reg;
        target_next   = target_reg;
        sel_next      = sel_reg;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_wdata     = value;
        mem_raddr     = head_reg;
        finish        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = ST_OK;
                    rd_next     = '0;
                    finish      = 1'b1;
                    unique case (func)
                        FN_PUSH_FRONT:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                if (cnt_reg != '0)
                                begin
                                    head_next = head_reg - PTR_W'(1);
                                end
                                else
                                begin
                                    back_next = value;
                                end
                                mem_we     = 1'b1;
                                mem_waddr  = head_next;
                                front_next = value;
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                head_next  = head_reg + PTR_W'(1);
                                cnt_next   = cnt_reg - CNT_W'(1);
                                mem_raddr  = head_reg + PTR_W'(1);
                                sel_next   = RD_FRONT;
                                finish     = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        FN_PUSH_BACK:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                if (cnt_reg == '0)
                                begin
                                    front_next = value;
                                end
                                mem_we    = 1'b1;
                                mem_waddr = head_reg + cnt_reg[PTR_W-1:0];
                                back_next = value;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg - CNT_W'(1);
                                mem_raddr  = head_reg + cnt_m2[PTR_W-1:0];
                                sel_next   = RD_BACK;
                                finish     = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        FN_READ_INDEX:
                        begin
                            if (position >= cnt_reg)
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                mem_raddr  = head_reg + position[PTR_W-1:0];
                                sel_next   = RD_INDEX;
                                finish     = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        FN_CLEAR:
                        begin
                            head_next = '0;
                            cnt_next  = '0;
                        end
                        FN_RESIZE:
                        begin
                            if (position > CNT_FULL)
                            begin
                                status_next = ST_BAD_SIZE;
                            end
                            else if (position == '0)
                            begin
                                head_next = '0;
                                cnt_next  = '0;
                            end
                            else if (position < cnt_reg)
                            begin
                                // shrink keeps the front; new back comes from the RAM
                                cnt_next   = position;
                                mem_raddr  = head_reg + pos_m1[PTR_W-1:0];
                                sel_next   = RD_BACK;
                                finish     = 1'b0;
                                state_next = S_READ;
                            end
                            else if (position > cnt_reg)
                            begin
                                if (cnt_reg == '0)
                                begin
                                    front_next = value;
                                end
                                fill_val_next = value;
                                fill_idx_next = cnt_reg;
                                target_next   = position;
                                finish        = 1'b0;
                                state_next    = S_FILL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                case (sel_reg)
                    RD_FRONT: front_next = mem_rdata;
                    RD_BACK:  back_next  = mem_rdata;
                    default:  rd_next    = mem_rdata;
                endcase
                finish = 1'b1;
            end
            S_FILL:
            begin
                mem_we        = 1'b1;
                mem_waddr     = head_reg + fill_idx_reg[PTR_W-1:0];
                mem_wdata     = fill_val_reg;
                fill_idx_next = fill_inc;
                if (fill_inc == target_reg)
                begin
                    cnt_next  = target_reg;
                    back_next = fill_val_reg;
                    finish    = 1'b1;
                end
            end
            S_EMIT:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result goes out now if the output register can take it, else it is held
        if (finish)
        begin
            state_next = res_free ? S_IDLE : S_EMIT;
        end
    end

    assign res_valid       = finish && res_free;
    assign res.status      = status_next;
    assign res.front_value = (cnt_next != '0) ? front_next : '0;
    assign res.back_value  = (cnt_next != '0) ? back_next : '0;
    assign res.read_value  = rd_next;
    assign res.count       = cnt_next;
    assign res.is_empty    = (cnt_next == '0);
    assign res.is_full     = (cnt_next == CNT_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        rd_reg       <= rd_next;
        front_reg    <= front_next;
        back_reg     <= back_next;
        fill_val_reg <= fill_val_next;
        fill_idx_reg <= fill_idx_next;
        target_reg   <= target_next;
        sel_reg      <= sel_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("element count above capacity");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (head_reg == '0))
        else $error("empty deque with head not at slot zero");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (fill_idx_reg < target_reg && target_reg <= CNT_FULL))
        else $error("fill walk out of range");

    a_read_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE || state_reg == S_EMIT))
        else $error("RAM read state did not finish in one cycle");

endmodule

// File: rtl/core/circular_double_ended_queue.sv
// Top level of the ring-buffer deque: RAM, sequencer and output register.
//
// Ring-buffer deque of 16 words of 32 bits, one result word per input word.
// Push, clear, no-op and every error case finish in the cycle the word is taken,
// so these run at one word per cycle unless the output register is held. A pop
// that leaves entries behind, an indexed read and a shrinking resize go through
// a read state: the new front, back or read value comes from the synchronous
// RAM in the cycle after the address is issued. A growing resize writes its new
// entries in a fill state, as the single RAM write port fills one slot a cycle.
// The front and back words are cached in registers so that no operation needs
// more than one RAM read. A finished result sits in the output register; while
// it is not taken the block can still accept one more word and holds its result.
module circular_double_ended_queue
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [DATA_W-1:0] value,
    input  logic [CNT_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] back_value,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]         count,
    output logic                     is_empty,
    output logic                     is_full
);

    logic              res_valid;
    logic              res_free;
    res_t              res;
    res_t              out_reg;
    logic              out_valid_reg;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [PTR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    assign res_free = !out_valid_reg || out_ready;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .position  (position),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    cdq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign front_value = out_reg.front_value;
    assign back_value  = out_reg.back_value;
    assign read_value  = out_reg.read_value;
    assign count       = out_reg.count;
    assign is_empty    = out_reg.is_empty;
    assign is_full     = out_reg.is_full;

endmodule
